// ----- hw/rtl/log2f_pkg.sv -----
// shared constants for the fixed-point log2 pipeline
`timescale 1ns / 1ps

package log2f_pkg;

    localparam int MAX_FRAC_DEF = 8;
    localparam int VALUE_W      = 32;
    localparam int LOG_W        = 14;
    localparam int FRAC_W       = 4;
    localparam int IDX_W        = 5;
    localparam int X_W          = 17;
    localparam int SQ_W         = 32;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd3;
    localparam logic [SQ_W-1:0]   ROUND_BIAS = 32'h0000_7FFF;
    localparam logic [X_W-1:0]    HALF_Q15   = 17'h0_8000;

endpackage

// ----- hw/rtl/fixed_point_log2_frac.sv -----
// fixed-point base-2 logarithm with a configurable fraction width, fully pipelined
`timescale 1ns / 1ps

// channel | signals                              | direction
// --------+--------------------------------------+----------
// operand | value_valid, value_ready, value      | in
// result  | log_valid, log_ready, log_value      | out
// config  | cfg_valid, cfg_ready, frac_bits      | in
//
// one transaction per cycle while the pipe is not held; one squaring stage per result bit
// follows the msb search and normalising stages
// reset clears the valid bits and loads the fraction count with three
// the whole pipe holds while the result register is full and log_ready is low
// cfg_ready is always high

module fixed_point_log2_frac #(
    parameter int MAX_FRAC = log2f_pkg::MAX_FRAC_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           value_valid,
    output logic                           value_ready,
    input  logic [log2f_pkg::VALUE_W-1:0]  value,
    output logic                           log_valid,
    input  logic                           log_ready,
    output logic [log2f_pkg::LOG_W-1:0]    log_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [log2f_pkg::FRAC_W-1:0]   frac_bits
);

    localparam int NIT = MAX_FRAC + 1;
    localparam int FW  = $clog2(MAX_FRAC + 2);
    localparam int TW  = NIT;
    localparam int RW  = (MAX_FRAC + 6 > log2f_pkg::LOG_W) ? MAX_FRAC + 6 : log2f_pkg::LOG_W;
    localparam int VW  = log2f_pkg::VALUE_W;
    localparam int IW  = log2f_pkg::IDX_W;
    localparam int XW  = log2f_pkg::X_W;
    localparam int SW  = log2f_pkg::SQ_W;

    logic                          en;
    logic [log2f_pkg::FRAC_W-1:0]  frac_bits_reg;
    logic [FW-1:0]                 frac_eff;

    // stage a: operand
    logic                          vld_a_reg;
    logic [VW-1:0]                 v_a_reg;
    logic [FW-1:0]                 frac_a_reg;
    logic [IW-1:0]                 idx_a;
    logic                          spec_a;

    // stage b: msb index known
    logic                          vld_b_reg;
    logic [VW-1:0]                 v_b_reg;
    logic [IW-1:0]                 idx_b_reg;
    logic                          spec_b_reg;
    logic [FW-1:0]                 frac_b_reg;
    logic [XW-1:0]                 x_norm;
    logic [VW-1:0]                 v_dec;
    logic [VW-1:0]                 shr;
    logic [VW-1:0]                 shl;

    // squaring stages
    logic                          vld_it_reg  [0:NIT];
    logic [XW-1:0]                 x_reg       [0:NIT];
    logic [TW-1:0]                 t_reg       [0:NIT];
    logic [IW-1:0]                 idx_it_reg  [0:NIT];
    logic                          spec_it_reg [0:NIT];
    logic [FW-1:0]                 frac_it_reg [0:NIT];

    // result
    logic                          vld_out_reg;
    logic [log2f_pkg::LOG_W-1:0]   log_out_reg;
    logic [RW-1:0]                 sum;
    logic [RW-1:0]                 int_part;

    assign en          = !vld_out_reg || log_ready;
    assign value_ready = en;
    assign cfg_ready   = 1'b1;
    assign log_valid   = vld_out_reg;
    assign log_value   = log_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_bits_reg <= log2f_pkg::FRAC_RESET;
        end
        else if (cfg_valid)
        begin
            frac_bits_reg <= frac_bits;
        end
    end

    // counts above the supported depth saturate
    always_comb
    begin
        if (int'(frac_bits_reg) > MAX_FRAC)
        begin
            frac_eff = FW'(MAX_FRAC);
        end
        else
        begin
            frac_eff = FW'(frac_bits_reg);
        end
    end

    // ---------------- stage a ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= value_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_a_reg    <= value;
            frac_a_reg <= frac_eff;
        end
    end

    // msb position; zero lands on index 0 and counts as a power of two
    always_comb
    begin
        idx_a = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (v_a_reg[i])
            begin
                idx_a = IW'(i);
            end
        end
        spec_a = ((v_a_reg & (v_a_reg - VW'(1))) == '0);
    end

    // ---------------- stage b ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_b_reg    <= v_a_reg;
            idx_b_reg  <= idx_a;
            spec_b_reg <= spec_a;
            frac_b_reg <= frac_a_reg;
        end
    end

    // normalise into the range 2^15 to 2^16, rounding upward when bits are dropped
    always_comb
    begin
        v_dec = v_b_reg - VW'(1);
        shr   = (v_dec >> (idx_b_reg - IW'(15))) + VW'(1);
        shl   = v_b_reg << (IW'(15) - idx_b_reg);
        if (idx_b_reg >= IW'(16))
        begin
            x_norm = shr[XW-1:0];
        end
        else
        begin
            x_norm = shl[XW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_it_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_it_reg[0] <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]       <= x_norm;
            t_reg[0]       <= '0;
            idx_it_reg[0]  <= idx_b_reg;
            spec_it_reg[0] <= spec_b_reg;
            frac_it_reg[0] <= frac_b_reg;
        end
    end

    // ---------------- squaring stages ----------------
    for (genvar k = 0; k < NIT; k++)
    begin : g_iter
        logic            act;
        logic            bit_int;
        logic [XW:0]     inc;
        logic [XW-1:0]   half;
        logic [2*XW-1:0] prod;
        logic [SW:0]     rnd;
        logic [XW-1:0]   x_next;
        logic [TW-1:0]   t_next;

        always_comb
        begin
            act     = (frac_it_reg[k] >= FW'(k));
            bit_int = x_reg[k][XW-1];
            inc     = {1'b0, x_reg[k]} + {{XW{1'b0}}, bit_int};
            if (bit_int)
            begin
                half = inc[XW:1];
            end
            else
            begin
                half = inc[XW-1:0];
            end
            prod = half * half;
            // square wraps modulo 2^32 before the q15 rounding
            rnd  = {1'b0, prod[SW-1:0]} + {1'b0, log2f_pkg::ROUND_BIAS};
            if (act)
            begin
                x_next = rnd[SW-1:15];
                t_next = (t_reg[k] << 1) | TW'(bit_int);
            end
            else
            begin
                x_next = x_reg[k];
                t_next = t_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_it_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_it_reg[k+1] <= vld_it_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]       <= x_next;
                t_reg[k+1]       <= t_next;
                idx_it_reg[k+1]  <= idx_it_reg[k];
                spec_it_reg[k+1] <= spec_it_reg[k];
                frac_it_reg[k+1] <= frac_it_reg[k];
            end
        end
    end

    // ---------------- result ----------------
    always_comb
    begin
        int_part = RW'(idx_it_reg[NIT]) << frac_it_reg[NIT];
        if (spec_it_reg[NIT])
        begin
            sum = int_part;
        end
        else
        begin
            sum = int_part + RW'(t_reg[NIT])
                + RW'(x_reg[NIT] > log2f_pkg::HALF_Q15);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_out_reg <= vld_it_reg[NIT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            log_out_reg <= sum[log2f_pkg::LOG_W-1:0];
        end
    end

endmodule
